// File: src/scpg_pkg.sv
// shared types and constants of the servo command pwm generator
`default_nettype none

package scpg_pkg;

   localparam int unsigned CNT_W  = 16;
   localparam int unsigned WID_W  = 12;
   localparam int unsigned LVL_W  = 4;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned IDX_W  = 3;

   typedef enum logic [IDX_W-1:0] {
      REG_PERIOD_TOP     = 3'd0,
      REG_WINDOW_LOW     = 3'd1,
      REG_WINDOW_HIGH    = 3'd2,
      REG_ROT_ON_WIDTH   = 3'd3,
      REG_ROT_OFF_WIDTH  = 3'd4,
      REG_OPEN_ON_WIDTH  = 3'd5,
      REG_OPEN_OFF_WIDTH = 3'd6
   } reg_index_type;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_CMD  = 1'b1;

   localparam logic [BYTE_W-1:0] CMD_CHECK_MASK = 8'b1000_0001;
   localparam int unsigned CMD_GRIP_HI  = 6;
   localparam int unsigned CMD_GRIP_LO  = 5;
   localparam int unsigned CMD_ROT_BIT  = 4;
   localparam int unsigned CMD_OPEN_BIT = 3;
   localparam int unsigned GRIP_SEL_W   = CMD_GRIP_HI - CMD_GRIP_LO + 1;

   localparam logic [CNT_W-1:0] RST_PERIOD_TOP     = 16'd19999;
   localparam logic [CNT_W-1:0] RST_WINDOW_LOW     = 16'd500;
   localparam logic [CNT_W-1:0] RST_WINDOW_HIGH    = 16'd2500;
   localparam logic [WID_W-1:0] RST_ROT_ON_WIDTH   = 12'd2300;
   localparam logic [WID_W-1:0] RST_ROT_OFF_WIDTH  = 12'd1000;
   localparam logic [WID_W-1:0] RST_OPEN_ON_WIDTH  = 12'd2000;
   localparam logic [WID_W-1:0] RST_OPEN_OFF_WIDTH = 12'd600;
   localparam logic [WID_W-1:0] RST_STORED_WIDTH   = 12'd1000;

   typedef struct packed {
      logic [CNT_W-1:0] period_top;
      logic [CNT_W-1:0] window_low;
      logic [CNT_W-1:0] window_high;
      logic [WID_W-1:0] rot_on_width;
      logic [WID_W-1:0] rot_off_width;
      logic [WID_W-1:0] open_on_width;
      logic [WID_W-1:0] open_off_width;
   } cfg_type;

   typedef struct packed {
      logic [LVL_W-1:0] rot_levels;
      logic [LVL_W-1:0] open_levels;
      logic             reply_valid;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/scpg_csr.sv
// apb-style configuration register file
`default_nettype none

module scpg_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [scpg_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [scpg_pkg::DATA_W-1:0]   pwdata,
   output logic      [scpg_pkg::DATA_W-1:0]   prdata,
   output logic                               pready,
   output scpg_pkg::cfg_type                  cfg
);
   import scpg_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PERIOD_TOP:     cfg_in.period_top     = pwdata[CNT_W-1:0];
            REG_WINDOW_LOW:     cfg_in.window_low     = pwdata[CNT_W-1:0];
            REG_WINDOW_HIGH:    cfg_in.window_high    = pwdata[CNT_W-1:0];
            REG_ROT_ON_WIDTH:   cfg_in.rot_on_width   = pwdata[WID_W-1:0];
            REG_ROT_OFF_WIDTH:  cfg_in.rot_off_width  = pwdata[WID_W-1:0];
            REG_OPEN_ON_WIDTH:  cfg_in.open_on_width  = pwdata[WID_W-1:0];
            REG_OPEN_OFF_WIDTH: cfg_in.open_off_width = pwdata[WID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PERIOD_TOP:     prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_ff.period_top};
         REG_WINDOW_LOW:     prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_ff.window_low};
         REG_WINDOW_HIGH:    prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_ff.window_high};
         REG_ROT_ON_WIDTH:   prdata = {{(DATA_W-WID_W){1'b0}}, cfg_ff.rot_on_width};
         REG_ROT_OFF_WIDTH:  prdata = {{(DATA_W-WID_W){1'b0}}, cfg_ff.rot_off_width};
         REG_OPEN_ON_WIDTH:  prdata = {{(DATA_W-WID_W){1'b0}}, cfg_ff.open_on_width};
         REG_OPEN_OFF_WIDTH: prdata = {{(DATA_W-WID_W){1'b0}}, cfg_ff.open_off_width};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_top     <= RST_PERIOD_TOP;
         cfg_ff.window_low     <= RST_WINDOW_LOW;
         cfg_ff.window_high    <= RST_WINDOW_HIGH;
         cfg_ff.rot_on_width   <= RST_ROT_ON_WIDTH;
         cfg_ff.rot_off_width  <= RST_ROT_OFF_WIDTH;
         cfg_ff.open_on_width  <= RST_OPEN_ON_WIDTH;
         cfg_ff.open_off_width <= RST_OPEN_OFF_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: src/scpg_core.sv
// period counter, stored gripper widths and output level logic
`default_nettype none

module scpg_core #(
   parameter int unsigned NUM_GRIPPERS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic                          req_type,
   input  wire logic [scpg_pkg::BYTE_W-1:0]   cmd_byte,
   input  scpg_pkg::cfg_type                  cfg,
   output scpg_pkg::rsp_type                  result
);
   import scpg_pkg::*;

   logic [CNT_W-1:0]      tick_count_ff;
   logic [CNT_W-1:0]      tick_count_in;
   logic [WID_W-1:0]      rot_widths_ff  [NUM_GRIPPERS];
   logic [WID_W-1:0]      rot_widths_in  [NUM_GRIPPERS];
   logic [WID_W-1:0]      open_widths_ff [NUM_GRIPPERS];
   logic [WID_W-1:0]      open_widths_in [NUM_GRIPPERS];
   logic [LVL_W-1:0]      rot_out_ff;
   logic [LVL_W-1:0]      rot_out_in;
   logic [LVL_W-1:0]      open_out_ff;
   logic [LVL_W-1:0]      open_out_in;
   logic                  reply;
   logic                  at_zero;
   logic                  in_window;
   logic                  at_top;
   logic                  cmd_ok;
   logic [GRIP_SEL_W-1:0] grip_sel;
   logic [WID_W-1:0]      new_rot_width;
   logic [WID_W-1:0]      new_open_width;

   assign at_zero   = (tick_count_ff == '0);
   assign in_window = (tick_count_ff >= cfg.window_low) && (tick_count_ff <= cfg.window_high);
   assign at_top    = (tick_count_ff >= cfg.period_top);
   assign cmd_ok    = ((cmd_byte & CMD_CHECK_MASK) == CMD_CHECK_MASK);
   assign grip_sel  = cmd_byte[CMD_GRIP_HI:CMD_GRIP_LO];
   assign new_rot_width  = cmd_byte[CMD_ROT_BIT]  ? cfg.rot_on_width  : cfg.rot_off_width;
   assign new_open_width = cmd_byte[CMD_OPEN_BIT] ? cfg.open_on_width : cfg.open_off_width;

   always_comb begin
      tick_count_in  = tick_count_ff;
      rot_out_in     = rot_out_ff;
      open_out_in    = open_out_ff;
      rot_widths_in  = rot_widths_ff;
      open_widths_in = open_widths_ff;
      reply          = 1'b0;
      if (req_type == REQ_TICK) begin
         for (int i = 0; i < NUM_GRIPPERS; i++) begin
            // set at count zero, then the window compare may clear in the same tick
            if (at_zero) begin
               rot_out_in[i]  = 1'b1;
               open_out_in[i] = 1'b1;
            end
            if (in_window && (tick_count_ff >= {{(CNT_W-WID_W){1'b0}}, rot_widths_ff[i]})) begin
               rot_out_in[i] = 1'b0;
            end
            if (in_window && (tick_count_ff > {{(CNT_W-WID_W){1'b0}}, open_widths_ff[i]})) begin
               open_out_in[i] = 1'b0;
            end
         end
         tick_count_in = at_top ? '0 : tick_count_ff + 1'b1;
      end else if (cmd_ok) begin
         for (int i = 0; i < NUM_GRIPPERS; i++) begin
            if (grip_sel == GRIP_SEL_W'(i)) begin
               rot_widths_in[i]  = new_rot_width;
               open_widths_in[i] = new_open_width;
            end
         end
      end else begin
         reply = 1'b1;
      end
   end

   assign result.rot_levels  = rot_out_in;
   assign result.open_levels = open_out_in;
   assign result.reply_valid = reply;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         rot_out_ff    <= '0;
         open_out_ff   <= '0;
         for (int i = 0; i < NUM_GRIPPERS; i++) begin
            rot_widths_ff[i]  <= RST_STORED_WIDTH;
            open_widths_ff[i] <= RST_STORED_WIDTH;
         end
      end else if (step) begin
         tick_count_ff  <= tick_count_in;
         rot_out_ff     <= rot_out_in;
         open_out_ff    <= open_out_in;
         rot_widths_ff  <= rot_widths_in;
         open_widths_ff <= open_widths_in;
      end
   end

endmodule

`default_nettype wire

// File: src/servo_command_pwm_generator.sv
// Servo command PWM generator: four grippers, each with a rotate and an open
// pulse level. A request is either one counter tick (req_type 0) or a received
// command byte (req_type 1); every request yields exactly one response with the
// output levels after that request and, for a byte without both check bits,
// reply_valid set. Requests are taken one per clock: a request is registered on
// acceptance, processed in the following cycle by single-level compare logic
// against the stored widths and the period counter, and lands in the response
// register once that register is free or its held response is taken, and
// the block sustains one request per cycle while rsp_ready stays high. Back-pressure on
// the response side stalls the input register; req_ready drops only while a
// response is waiting and a further request is already held. Timing registers
// are written through the APB-style port and reset to a 20000-count period, a
// clear window of 500 to 2500 and widths 2300/1000 (rotate) and 2000/600 (open);
// stored per-gripper widths reset to 1000. Write registers only while idle.
`default_nettype none

module servo_command_pwm_generator #(
   parameter int unsigned NUM_GRIPPERS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [scpg_pkg::BYTE_W-1:0]   req_cmd_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [scpg_pkg::LVL_W-1:0]    rsp_rot_levels,
   output logic      [scpg_pkg::LVL_W-1:0]    rsp_open_levels,
   output logic                               rsp_reply_valid,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [scpg_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [scpg_pkg::DATA_W-1:0]   pwdata,
   output logic      [scpg_pkg::DATA_W-1:0]   prdata,
   output logic                               pready
);
   import scpg_pkg::*;

   cfg_type           cfg;
   rsp_type           result;
   rsp_type           rsp_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic              in_type_ff;
   logic [BYTE_W-1:0] in_cmd_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   scpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   scpg_core #(
      .NUM_GRIPPERS (NUM_GRIPPERS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_type (in_type_ff),
      .cmd_byte (in_cmd_ff),
      .cfg      (cfg),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff <= req_type;
         in_cmd_ff  <= req_cmd_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rot_levels  = rsp_ff.rot_levels;
   assign rsp_open_levels = rsp_ff.open_levels;
   assign rsp_reply_valid = rsp_ff.reply_valid;

endmodule

`default_nettype wire

// File: src/scpg_checker.sv
// port-level checks of the servo command pwm generator and their binding
`default_nettype none

module scpg_checker #(
   parameter int unsigned NUM_GRIPPERS = 4
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [scpg_pkg::LVL_W-1:0]    rsp_rot_levels,
   input wire logic [scpg_pkg::LVL_W-1:0]    rsp_open_levels,
   input wire logic                          rsp_reply_valid,
   input wire logic                          psel,
   input wire logic                          pready
);
   import scpg_pkg::*;

   localparam logic [LVL_W-1:0] USED_MASK = LVL_W'((1 << NUM_GRIPPERS) - 1);

   // no response right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rot_levels)
         && $stable(rsp_open_levels) && $stable(rsp_reply_valid))
      else $error("stalled response changed");

   // request side only stalls behind a blocked response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response back-pressure");

   // absent grippers never drive a level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_rot_levels & ~USED_MASK) == '0)
         && ((rsp_open_levels & ~USED_MASK) == '0))
      else $error("level set for an absent gripper");

   // configuration port never waits
   assert property (@(posedge clock) disable iff (reset) psel |-> pready)
      else $error("pready low");

endmodule

bind servo_command_pwm_generator scpg_checker #(
   .NUM_GRIPPERS (NUM_GRIPPERS)
) u_scpg_checker (.*);

`default_nettype wire

// File: tb/servo_command_pwm_generator_test.sv
// self-checking testbench for the servo command pwm generator
`timescale 1ns / 100ps

module servo_command_pwm_generator_test;
   import scpg_pkg::*;

   localparam int unsigned NUM_GRIPPERS = 4;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned SHOWN_LIMIT  = 40;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [BYTE_W-1:0]   req_cmd_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [LVL_W-1:0]    rsp_rot_levels;
   logic [LVL_W-1:0]    rsp_open_levels;
   logic                rsp_reply_valid;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   servo_command_pwm_generator #(
      .NUM_GRIPPERS(NUM_GRIPPERS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_cmd_byte(req_cmd_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_rot_levels(rsp_rot_levels),
      .rsp_open_levels(rsp_open_levels),
      .rsp_reply_valid(rsp_reply_valid),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // predicted servo state
   cfg_type           timing;
   logic [CNT_W-1:0]  count_now;
   logic [WID_W-1:0]  stored_rot_width [NUM_GRIPPERS];
   logic [WID_W-1:0]  stored_open_width [NUM_GRIPPERS];
   logic [LVL_W-1:0]  rot_level;
   logic [LVL_W-1:0]  open_level;

   rsp_type     pending_levels [$];
   bit          calm;
   int unsigned mismatches;
   int unsigned responses_checked;
   int unsigned ticks_sent;
   int unsigned commands_sent;
   int unsigned malformed_sent;
   int unsigned reg_writes;
   int unsigned cycle_count;
   int unsigned stall_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_levels.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [LVL_W-1:0] gripper_mask();
      return LVL_W'((1 << NUM_GRIPPERS) - 1);
   endfunction

   function automatic void reset_servo_state();
      timing.period_top     = RST_PERIOD_TOP;
      timing.window_low     = RST_WINDOW_LOW;
      timing.window_high    = RST_WINDOW_HIGH;
      timing.rot_on_width   = RST_ROT_ON_WIDTH;
      timing.rot_off_width  = RST_ROT_OFF_WIDTH;
      timing.open_on_width  = RST_OPEN_ON_WIDTH;
      timing.open_off_width = RST_OPEN_OFF_WIDTH;
      count_now  = '0;
      rot_level  = '0;
      open_level = '0;
      for (int i = 0; i < NUM_GRIPPERS; i++) begin
         stored_rot_width[i]  = RST_STORED_WIDTH;
         stored_open_width[i] = RST_STORED_WIDTH;
      end
   endfunction

   function automatic rsp_type servo_levels_after(input logic kind, input logic [BYTE_W-1:0] b);
      rsp_type                result;
      logic [GRIP_SEL_W-1:0]  grip;
      result = '0;
      if (kind == REQ_TICK) begin
         if (count_now == '0) begin
            rot_level  = gripper_mask();
            open_level = gripper_mask();
         end
         if (count_now >= timing.window_low && count_now <= timing.window_high) begin
            for (int i = 0; i < NUM_GRIPPERS; i++) begin
               if (count_now >= CNT_W'(stored_rot_width[i])) rot_level[i] = 1'b0;
               if (count_now > CNT_W'(stored_open_width[i])) open_level[i] = 1'b0;
            end
         end
         count_now = (count_now >= timing.period_top) ? '0 : count_now + 1'b1;
      end else if ((b & CMD_CHECK_MASK) == CMD_CHECK_MASK) begin
         grip = b[CMD_GRIP_HI:CMD_GRIP_LO];
         if (grip < NUM_GRIPPERS) begin
            stored_rot_width[grip]  = b[CMD_ROT_BIT] ? timing.rot_on_width : timing.rot_off_width;
            stored_open_width[grip] = b[CMD_OPEN_BIT] ? timing.open_on_width
                                                      : timing.open_off_width;
         end
      end else begin
         result.reply_valid = 1'b1;
      end
      result.rot_levels  = rot_level;
      result.open_levels = open_level;
      return result;
   endfunction

   function automatic logic [DATA_W-1:0] timing_reg_value(input reg_index_type idx);
      case (idx)
         REG_PERIOD_TOP:     return DATA_W'(timing.period_top);
         REG_WINDOW_LOW:     return DATA_W'(timing.window_low);
         REG_WINDOW_HIGH:    return DATA_W'(timing.window_high);
         REG_ROT_ON_WIDTH:   return DATA_W'(timing.rot_on_width);
         REG_ROT_OFF_WIDTH:  return DATA_W'(timing.rot_off_width);
         REG_OPEN_ON_WIDTH:  return DATA_W'(timing.open_on_width);
         default:            return DATA_W'(timing.open_off_width);
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] grip_cmd(input int unsigned grip, input bit rot_on,
                                                   input bit open_on);
      logic [BYTE_W-1:0] b;
      b = CMD_CHECK_MASK;
      b[CMD_GRIP_HI:CMD_GRIP_LO] = grip[GRIP_SEL_W-1:0];
      b[CMD_ROT_BIT]  = rot_on;
      b[CMD_OPEN_BIT] = open_on;
      return b;
   endfunction

   function automatic logic [DATA_W-1:0] random_width();
      if ($urandom_range(0, 9) == 0) return DATA_W'(4095);
      return DATA_W'($urandom_range(0, 50));
   endfunction

   task automatic report_field(input string what, input logic [LVL_W-1:0] want,
                               input logic [LVL_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= SHOWN_LIMIT)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : check_levels
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_LIMIT)
               $display("%0t: response with none expected, expected nothing got %h %h %b",
                        $time, rsp_rot_levels, rsp_open_levels, rsp_reply_valid);
         end else begin
            want = pending_levels.pop_front();
            responses_checked++;
            report_field("rot_levels", want.rot_levels, rsp_rot_levels);
            report_field("open_levels", want.open_levels, rsp_open_levels);
            report_field("reply_valid", LVL_W'(want.reply_valid), LVL_W'(rsp_reply_valid));
         end
      end
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (reset || calm) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic kind, input logic [BYTE_W-1:0] b);
      int unsigned gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_cmd_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_levels.push_back(servo_levels_after(kind, b));
      if (kind == REQ_TICK) ticks_sent++;
      else begin
         commands_sent++;
         if ((b & CMD_CHECK_MASK) != CMD_CHECK_MASK) malformed_sent++;
      end
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input logic write_en,
                             input logic [DATA_W-1:0] value, output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_reg(input reg_index_type idx);
      logic [DATA_W-1:0] got;
      csr_access(idx, 1'b0, '0, got);
      if (got !== timing_reg_value(idx)) begin
         mismatches++;
         if (mismatches <= SHOWN_LIMIT)
            $display("%0t: register %s expected %0d got %0d", $time, idx.name(),
                     timing_reg_value(idx), got);
      end
   endtask

   task automatic program_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] unused;
      hold_until_drained();
      csr_access(idx, 1'b1, value, unused);
      case (idx)
         REG_PERIOD_TOP:     timing.period_top     = value[CNT_W-1:0];
         REG_WINDOW_LOW:     timing.window_low     = value[CNT_W-1:0];
         REG_WINDOW_HIGH:    timing.window_high    = value[CNT_W-1:0];
         REG_ROT_ON_WIDTH:   timing.rot_on_width   = value[WID_W-1:0];
         REG_ROT_OFF_WIDTH:  timing.rot_off_width  = value[WID_W-1:0];
         REG_OPEN_ON_WIDTH:  timing.open_on_width  = value[WID_W-1:0];
         REG_OPEN_OFF_WIDTH: timing.open_off_width = value[WID_W-1:0];
         default: ;
      endcase
      reg_writes++;
      check_reg(idx);
   endtask

   task automatic test_reset_values();
      for (int i = 0; i <= int'(REG_OPEN_OFF_WIDTH); i++) check_reg(reg_index_type'(i));
      send_request(REQ_TICK, '0);
      send_request(REQ_CMD, grip_cmd(0, 1'b0, 1'b0));
      send_request(REQ_TICK, 8'hff);
   endtask

   // short period, full window: every gripper and both width choices
   task automatic test_command_decode();
      program_reg(REG_PERIOD_TOP, 5);
      program_reg(REG_WINDOW_LOW, 0);
      program_reg(REG_WINDOW_HIGH, 5);
      program_reg(REG_ROT_ON_WIDTH, 3);
      program_reg(REG_ROT_OFF_WIDTH, 0);
      program_reg(REG_OPEN_ON_WIDTH, 4);
      program_reg(REG_OPEN_OFF_WIDTH, 0);
      send_request(REQ_CMD, grip_cmd(0, 1'b0, 1'b0));
      send_request(REQ_CMD, grip_cmd(1, 1'b1, 1'b1));
      send_request(REQ_CMD, grip_cmd(2, 1'b1, 1'b0));
      send_request(REQ_CMD, grip_cmd(3, 1'b0, 1'b1));
      send_request(REQ_CMD, 8'h80);
      send_request(REQ_CMD, 8'h01);
      repeat (7) send_request(REQ_TICK, '0);
   endtask

   // counter above a lowered period wraps on the next tick
   task automatic test_period_wrap();
      while (count_now != 4) send_request(REQ_TICK, '0);
      program_reg(REG_PERIOD_TOP, 1);
      repeat (2) send_request(REQ_TICK, '0);
   endtask

   task automatic test_window_extremes();
      program_reg(REG_PERIOD_TOP, 0);
      program_reg(REG_WINDOW_LOW, 65535);
      program_reg(REG_WINDOW_HIGH, 0);
      program_reg(REG_ROT_ON_WIDTH, 4095);
      program_reg(REG_OPEN_ON_WIDTH, 4095);
      send_request(REQ_CMD, grip_cmd(2, 1'b1, 1'b1));
      repeat (2) send_request(REQ_TICK, '0);
      program_reg(REG_WINDOW_LOW, 0);
      program_reg(REG_WINDOW_HIGH, 65535);
      program_reg(REG_PERIOD_TOP, 65535);
      repeat (3) send_request(REQ_TICK, '0);
   endtask

   task automatic randomize_timing();
      int unsigned lo;
      int unsigned hi;
      int unsigned swap;
      lo = $urandom_range(0, 12);
      hi = $urandom_range(lo, 60);
      if ($urandom_range(0, 4) == 0) begin
         swap = lo;
         lo   = hi;
         hi   = swap;
      end
      program_reg(REG_PERIOD_TOP, $urandom_range(0, 48));
      program_reg(REG_WINDOW_LOW, lo);
      program_reg(REG_WINDOW_HIGH, hi);
      program_reg(REG_ROT_ON_WIDTH, random_width());
      program_reg(REG_ROT_OFF_WIDTH, random_width());
      program_reg(REG_OPEN_ON_WIDTH, random_width());
      program_reg(REG_OPEN_OFF_WIDTH, random_width());
   endtask

   task automatic test_random_traffic(input int unsigned items, input bit last_part);
      int unsigned pick;
      randomize_timing();
      for (int unsigned n = 0; n < items; n++) begin
         if (!last_part && n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         if (!last_part && n == items / 2) hold_until_drained();
         pick = $urandom_range(0, 99);
         if (pick < 70) send_request(REQ_TICK, BYTE_W'($urandom));
         else if (pick < 90) send_request(REQ_CMD, BYTE_W'($urandom) | CMD_CHECK_MASK);
         else send_request(REQ_CMD, BYTE_W'($urandom));
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = REQ_TICK;
      req_cmd_byte = '0;
      rsp_ready    = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      calm         = 1'b0;
      reset_servo_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_command_decode();
      test_period_wrap();
      test_window_extremes();
      repeat (5) test_random_traffic(150, 1'b0);
      calm = 1'b1;
      test_random_traffic(50, 1'b1);

      hold_until_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d ticks and %0d command bytes (%0d malformed) over %0d register writes",
               ticks_sent, commands_sent, malformed_sent, reg_writes);
      $display("%0d responses compared, %0d mismatches", responses_checked, mismatches);
      if (mismatches == 0 && pending_levels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
